[rtl/gsps_pkg.sv]
package gsps_pkg;

    // Shared multiplier operand and product widths
    localparam int OPW   = 21;
    localparam int PRODW = 2 * OPW;

    // Reciprocal constants: x / d == (x * RECIP) >> SHIFT over the ranges used here
    localparam int RECIP_500 = 268436;   // exact for x < 493447
    localparam int SHIFT_500 = 27;
    localparam int RECIP_100 = 656;      // exact for x < 1024
    localparam int SHIFT_100 = 16;
    localparam int RECIP_10  = 838861;   // exact for x < 2^22
    localparam int SHIFT_10  = 23;

    // Numerator at or above this saturates the command to full scale
    localparam int NUM_SAT = 655360;

    // Configuration register indexes
    localparam logic REG_STEER_CENTER   = 1'b0;
    localparam logic REG_VEHICLE_NUMBER = 1'b1;

    // Vehicle codes with a gain table
    localparam logic [1:0] VEH_1 = 2'd1;
    localparam logic [1:0] VEH_2 = 2'd2;
    localparam logic [1:0] VEH_3 = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_Q500,
        ST_Q100,
        ST_KP,
        ST_KD,
        ST_CTR,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic en;     // load product register
        logic acc;    // add to current product instead of replacing it
    } mac_ctl_t;

    typedef struct packed {
        logic        hit;   // a table entry matched
        logic [12:0] kp;    // proportional gain, tenths
        logic [3:0]  kd;    // derivative gain
    } gain_t;

endpackage

[rtl/gain_scheduled_pd_steering.sv]
// Gain-scheduled PD steering. Each input item carries one camera frame's signed
// lane offset (tdata[9:0]) with road_lost and turning flags in tuser. A normal
// frame looks up kp (tenths) and kd from the table set picked by vehicle_number
// and turning, keyed on |offset| and partly scaled by offset^2/100 or /500, then
// forms (10*center + kp*off + 10*kd*(off - last_off)) / 10, truncated toward
// zero and clamped to 0..65535. Vehicle number 0 keeps the gains last used. A
// road-lost frame returns the truncated mean of the last two commands and leaves
// gains and the stored offset alone. All arithmetic runs through one registered
// 21x21 signed multiply-accumulate unit: squaring, two reciprocal divides for the
// schedule, the three product terms and a reciprocal divide by ten. A normal
// frame steps through SQ, Q500, Q100, KP, KD, CTR, DIV and FIN, a road-lost
// frame goes straight to FIN, then to IDLE. The input is ready only
// while the sequencer is idle; a finished result sits in the output register
// while the next item is taken, and a result that is not yet taken holds the
// sequencer in its last step. Configuration writes are always ready and must
// come only while the block is idle.
module gain_scheduled_pd_steering (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,     // 0: steer_center, 1: vehicle_number
    input  logic [15:0] cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [9:0] lane_offset, [15:10] zero
    input  logic [1:0]  s_axis_tuser,  // [0] road_lost, [1] turning
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [15:0] steer_command
);
    import gsps_pkg::*;

    state_t state_reg, state_next;

    // configuration
    logic [15:0] center_reg;
    logic [1:0]  vehicle_reg;

    // controller state
    logic [15:0]       prev_cmd_reg;
    logic [15:0]       prev_prev_cmd_reg;
    logic signed [9:0] prev_off_reg;
    logic [12:0]       gain_p_reg;
    logic [3:0]        gain_d_reg;

    // current item and intermediates
    logic signed [9:0] off_reg;
    logic              lost_reg;
    logic              turn_reg;
    logic [9:0]        sq_reg;
    logic [9:0]        q500_reg;
    logic              neg_reg;
    logic              big_reg;

    // output register
    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    // shared unit
    mac_ctl_t                mac_ctl;
    logic signed [OPW-1:0]   op_a;
    logic signed [OPW-1:0]   op_b;
    logic signed [PRODW-1:0] prod;

    gain_t       gain;
    logic [12:0] kp_sel;
    logic [7:0]  kd10;
    logic [10:0] off_diff;
    logic [16:0] hist_sum;
    logic [15:0] cmd;
    logic        in_take;
    logic        out_free;

    assign in_take  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    gsps_mac u_mac (
        .clk  (clk),
        .ctl  (mac_ctl),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // q100 only matters when |offset| < 26, so sq < 676
    gsps_gain u_gain (
        .vehicle_number (vehicle_reg),
        .turning        (turn_reg),
        .lane_offset    (off_reg),
        .q100           (prod[SHIFT_100+3:SHIFT_100]),
        .q500           (q500_reg),
        .gain           (gain)
    );

    always_comb
    begin
        kp_sel   = gain.hit ? gain.kp : gain_p_reg;
        kd10     = {1'b0, gain_d_reg, 3'd0} + {3'd0, gain_d_reg, 1'b0};
        off_diff = {off_reg[9], off_reg} - {prev_off_reg[9], prev_off_reg};
        hist_sum = {1'b0, prev_cmd_reg} + {1'b0, prev_prev_cmd_reg};
        priority if (lost_reg) cmd = hist_sum[16:1];
        else if (neg_reg)      cmd = 16'd0;
        else if (big_reg)      cmd = 16'hFFFF;
        else                   cmd = prod[SHIFT_10+15:SHIFT_10];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = s_axis_tuser[0] ? ST_FIN : ST_SQ;
                end
            end
            ST_SQ:   state_next = ST_Q500;
            ST_Q500: state_next = ST_Q100;
            ST_Q100: state_next = ST_KP;
            ST_KP:   state_next = ST_KD;
            ST_KD:   state_next = ST_CTR;
            ST_CTR:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // multiplier operands per step
    always_comb
    begin
        mac_ctl = '{en: 1'b0, acc: 1'b0};
        op_a    = '0;
        op_b    = '0;
        unique case (state_reg)
            ST_SQ:
            begin
                mac_ctl.en = 1'b1;
                op_a       = {{(OPW-10){off_reg[9]}}, off_reg};
                op_b       = {{(OPW-10){off_reg[9]}}, off_reg};
            end
            ST_Q500:
            begin
                mac_ctl.en = 1'b1;
                op_a       = {{(OPW-19){1'b0}}, prod[18:0]};
                op_b       = OPW'(RECIP_500);
            end
            ST_Q100:
            begin
                mac_ctl.en = 1'b1;
                op_a       = {{(OPW-10){1'b0}}, sq_reg};
                op_b       = OPW'(RECIP_100);
            end
            ST_KP:
            begin
                mac_ctl.en = 1'b1;
                op_a       = {{(OPW-13){1'b0}}, kp_sel};
                op_b       = {{(OPW-10){off_reg[9]}}, off_reg};
            end
            ST_KD:
            begin
                mac_ctl    = '{en: 1'b1, acc: 1'b1};
                op_a       = {{(OPW-8){1'b0}}, kd10};
                op_b       = {{(OPW-11){off_diff[10]}}, off_diff};
            end
            ST_CTR:
            begin
                mac_ctl    = '{en: 1'b1, acc: 1'b1};
                op_a       = {{(OPW-16){1'b0}}, center_reg};
                op_b       = OPW'(10);
            end
            ST_DIV:
            begin
                // only used when 0 <= num < NUM_SAT
                mac_ctl.en = 1'b1;
                op_a       = prod[OPW-1:0];
                op_b       = OPW'(RECIP_10);
            end
            ST_IDLE, ST_FIN:
            begin
                mac_ctl = '{en: 1'b0, acc: 1'b0};
            end
            default:
            begin
                mac_ctl = '{en: 1'b0, acc: 1'b0};
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            center_reg        <= '0;
            vehicle_reg       <= '0;
            prev_cmd_reg      <= '0;
            prev_prev_cmd_reg <= '0;
            prev_off_reg      <= '0;
            gain_p_reg        <= '0;
            gain_d_reg        <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_STEER_CENTER:   center_reg  <= cfg_data;
                    REG_VEHICLE_NUMBER: vehicle_reg <= cfg_data[1:0];
                    default:            center_reg  <= center_reg;
                endcase
            end

            if (state_reg == ST_KP && gain.hit)
            begin
                gain_p_reg <= gain.kp;
                gain_d_reg <= gain.kd;
            end

            if (state_reg == ST_KD)
            begin
                prev_off_reg <= off_reg;
            end

            if (state_reg == ST_FIN && out_free)
            begin
                out_valid_reg     <= 1'b1;
                prev_prev_cmd_reg <= prev_cmd_reg;
                prev_cmd_reg      <= cmd;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload and intermediates
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            off_reg  <= s_axis_tdata[9:0];
            lost_reg <= s_axis_tuser[0];
            turn_reg <= s_axis_tuser[1];
        end
        if (state_reg == ST_Q500)
        begin
            sq_reg <= prod[9:0];
        end
        if (state_reg == ST_Q100)
        begin
            q500_reg <= prod[SHIFT_500+9:SHIFT_500];
        end
        if (state_reg == ST_DIV)
        begin
            neg_reg <= prod[PRODW-1];
            big_reg <= !prod[PRODW-1] && (prod >= PRODW'(NUM_SAT));
        end
        if (state_reg == ST_FIN && out_free)
        begin
            out_data_reg <= cmd;
        end
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[rtl/gsps_mac.sv]
module gsps_mac (
    input  logic                                  clk,
    input  gsps_pkg::mac_ctl_t                    ctl,
    input  logic signed [gsps_pkg::OPW-1:0]       op_a,
    input  logic signed [gsps_pkg::OPW-1:0]       op_b,
    output logic signed [gsps_pkg::PRODW-1:0]     prod
);
    import gsps_pkg::*;

    logic signed [PRODW-1:0] prod_reg;
    logic signed [PRODW-1:0] prod_next;
    logic signed [PRODW-1:0] mul;
    logic signed [PRODW-1:0] base;

    always_comb
    begin
        mul       = op_a * op_b;
        base      = ctl.acc ? prod_reg : '0;
        prod_next = base + mul;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

[rtl/gsps_gain.sv]
module gsps_gain (
    input  logic [1:0]        vehicle_number,
    input  logic              turning,
    input  logic signed [9:0] lane_offset,
    input  logic [3:0]        q100,
    input  logic [9:0]        q500,
    output gsps_pkg::gain_t   gain
);
    import gsps_pkg::*;

    logic [9:0]  mag;
    logic [12:0] add100;
    logic [12:0] add500;
    logic        lt5, lt6, lt9, lt14, lt26;

    always_comb
    begin
        mag    = lane_offset[9] ? (~lane_offset + 10'd1) : lane_offset;
        add100 = {6'd0, q100, 3'd0} + {8'd0, q100, 1'b0};
        add500 = {q500, 3'd0} + {2'd0, q500, 1'b0};
        lt5    = mag < 10'd5;
        lt6    = mag < 10'd6;
        lt9    = mag < 10'd9;
        lt14   = mag < 10'd14;
        lt26   = mag < 10'd26;

        gain = '{hit: 1'b1, kp: 13'd0, kd: 4'd5};
        priority if (vehicle_number == VEH_3 && !turning)
        begin
            priority if (lt6)  gain.kp = 13'd80;
            else if (lt26)
            begin
                gain.kp = 13'd72 + add100;
                gain.kd = 4'd10;
            end
            else               gain.kp = 13'd108 + add500;
        end
        else if (vehicle_number == VEH_3)
        begin
            priority if (lt5)  gain.kp = 13'd200;
            else if (lt9)      gain.kp = 13'd300;
            else if (lt14)     gain.kp = 13'd420;
            else if (lt26)     gain.kp = 13'd582 + add100;
            else               gain.kp = 13'd368 + add500;
        end
        else if (vehicle_number == VEH_2 && turning)
        begin
            priority if (lt5)  gain.kp = 13'd140;
            else if (lt9)      gain.kp = 13'd240;
            else if (lt14)     gain.kp = 13'd320;
            else if (lt26)     gain.kp = 13'd382 + add100;
            else               gain.kp = 13'd268 + add500;
        end
        else if (vehicle_number == VEH_2)
        begin
            priority if (lt6)  gain.kp = 13'd170;
            else if (lt26)
            begin
                gain.kp = 13'd210 + add100;
                gain.kd = 4'd10;
            end
            else               gain.kp = 13'd260 + add500;
        end
        else if (vehicle_number == VEH_1)
        begin
            priority if (lt6)  gain.kp = 13'd60;
            else if (lt26)
            begin
                gain.kp = 13'd158 + add100;
                gain.kd = 4'd10;
            end
            else               gain.kp = 13'd162 + add500;
        end
        else
        begin
            // no table for this vehicle: previous gains stay
            gain.hit = 1'b0;
        end
    end

endmodule

[dv/gain_scheduled_pd_steering_test.sv]
module gain_scheduled_pd_steering_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gsps_pkg::*;

    // Cycles without any handshake before the run is declared hung. The slowest
    // item is a long sender gap plus the sequencer's work plus a long output
    // stall; this limit leaves a wide margin.
    localparam int HANG_LIMIT = 2000;
    localparam int RANDOM_FRAMES = 510;

    // Predicts steer_command per frame and holds the commands still owed by
    // the block. It keeps its own copy of the registers, the command history,
    // the last offset and the scheduled gains.
    class steer_cmd_board;
        logic [15:0] center;
        logic [1:0]  vehicle;
        logic [15:0] last_cmd;
        logic [15:0] older_cmd;
        int          last_off;
        int          kp_tenths;
        int          kd;
        logic [15:0] pending_cmds[$];
        int          errors;

        function void clear();
            center    = '0;
            vehicle   = '0;
            last_cmd  = '0;
            older_cmd = '0;
            last_off  = 0;
            kp_tenths = 0;
            kd        = 0;
            errors    = 0;
            pending_cmds.delete();
        endfunction

        function void write_reg(logic idx, logic [15:0] val);
            if (idx == REG_STEER_CENTER)
                center = val;
            else
                vehicle = val[1:0];
        endfunction

        // Gain schedule; no match (vehicle 0) leaves the gains alone
        function void schedule_gains(int off, bit turn);
            int mag;
            int sq100;
            int sq500;
            mag   = (off < 0) ? -off : off;
            sq100 = 10 * ((off * off) / 100);
            sq500 = 10 * ((off * off) / 500);
            if (vehicle == VEH_3 && !turn) begin
                if (mag < 6)       begin kp_tenths = 80;          kd = 5;  end
                else if (mag < 26) begin kp_tenths = 72 + sq100;  kd = 10; end
                else               begin kp_tenths = 108 + sq500; kd = 5;  end
            end
            else if (vehicle == VEH_3) begin
                kd = 5;
                if (mag < 5)       kp_tenths = 200;
                else if (mag < 9)  kp_tenths = 300;
                else if (mag < 14) kp_tenths = 420;
                else if (mag < 26) kp_tenths = 582 + sq100;
                else               kp_tenths = 368 + sq500;
            end
            else if (vehicle == VEH_2 && turn) begin
                kd = 5;
                if (mag < 5)       kp_tenths = 140;
                else if (mag < 9)  kp_tenths = 240;
                else if (mag < 14) kp_tenths = 320;
                else if (mag < 26) kp_tenths = 382 + sq100;
                else               kp_tenths = 268 + sq500;
            end
            else if (vehicle == VEH_2) begin
                if (mag < 6)       begin kp_tenths = 170;         kd = 5;  end
                else if (mag < 26) begin kp_tenths = 210 + sq100; kd = 10; end
                else               begin kp_tenths = 260 + sq500; kd = 5;  end
            end
            else if (vehicle == VEH_1) begin
                if (mag < 6)       begin kp_tenths = 60;          kd = 5;  end
                else if (mag < 26) begin kp_tenths = 158 + sq100; kd = 10; end
                else               begin kp_tenths = 162 + sq500; kd = 5;  end
            end
        endfunction

        function void frame_accepted(logic [9:0] off_bits, bit lost, bit turn);
            int          off;
            longint      num;
            longint      quot;
            logic [15:0] cmd;
            off = $signed(off_bits);
            if (lost) begin
                // mean of the last two commands; gains and last offset untouched
                cmd = 16'((int'(last_cmd) + int'(older_cmd)) / 2);
            end
            else begin
                schedule_gains(off, turn);
                num = 10 * longint'(center) + longint'(kp_tenths) * off
                    + 10 * longint'(kd) * (off - last_off);
                quot = num / 10;    // truncates toward zero
                if (quot < 0)
                    quot = 0;
                if (quot > 65535)
                    quot = 65535;
                cmd = 16'(quot);
                last_off = off;
            end
            older_cmd = last_cmd;
            last_cmd  = cmd;
            pending_cmds.push_back(cmd);
        endfunction

        function void command_seen(logic [15:0] got);
            logic [15:0] want;
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected steer_command, expected none, got %0d",
                         $time, got);
                errors++;
            end
            else begin
                want = pending_cmds.pop_front();
                if (got !== want) begin
                    $display("%0t: steer_command mismatch, expected %0d, got %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // [9:0] lane_offset, [15:10] zero
    logic [1:0]  s_axis_tuser;    // [0] road_lost, [1] turning
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [15:0] steer_command

    steer_cmd_board board;
    bit             steady;       // phase with no idling on either side
    int             quiet_cycles;

    gain_scheduled_pd_steering uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offsets cluster around the |offset| thresholds, with extremes and
    // full-range noise mixed in
    function automatic logic [9:0] pick_offset();
        int          roll;
        logic [9:0]  mag;
        roll = $urandom_range(0, 9);
        if (roll < 5) begin
            mag = 10'($urandom_range(0, 30));
            return $urandom_range(0, 1) ? -mag : mag;
        end
        if (roll == 5) begin
            case ($urandom_range(0, 3))
                0:       return 10'h200;   // -512
                1:       return 10'h1ff;   // 511
                2:       return 10'h201;   // -511
                default: return 10'h000;
            endcase
        end
        return 10'($urandom_range(0, 1023));
    endfunction

    // Entered and left at a falling edge; valid stays high on return so that
    // back-to-back frames need no extra assignment
    task automatic send_frame(logic [9:0] off, bit lost, bit turn);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, off};
        s_axis_tuser  <= {turn, lost};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.frame_accepted(off, lost, turn);
        @(negedge clk);
    endtask

    // Writes both registers back to back; only called with the block idle
    task automatic apply_setting(logic [15:0] center, logic [15:0] veh_word);
        cfg_valid <= 1'b1;
        cfg_index <= REG_STEER_CENTER;
        cfg_data  <= center;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(REG_STEER_CENTER, center);
        @(negedge clk);
        cfg_index <= REG_VEHICLE_NUMBER;
        cfg_data  <= veh_word;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(REG_VEHICLE_NUMBER, veh_word);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid, let every owed command come out, then keep waiting
    // so the sequencer is surely back in idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending_cmds.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    // Result side: random backpressure, changed at the falling edge
    initial
    begin : sink
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            board.command_seen(m_axis_tdata);
    end

    // Hang watchdog: any handshake restarts the count
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= HANG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int          random_sent;
        int          phase_len;
        int          roll;
        logic [15:0] center;
        logic [15:0] veh_word;

        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_STEER_CENTER;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        quiet_cycles  = 0;
        steady        = 1'b0;
        random_sent   = 0;
        board = new();
        board.clear();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Out of reset: no table, zero gains, center zero
        send_frame(10'h000, 1'b0, 1'b0);
        send_frame(10'h200, 1'b0, 1'b1);
        drain();

        // Vehicle 3 both tables, threshold edges, both offset extremes,
        // then a road-lost frame
        apply_setting(16'd32768, {14'b0, VEH_3});
        send_frame(10'd0,   1'b0, 1'b0);
        send_frame(10'd5,   1'b0, 1'b0);
        send_frame(10'd6,   1'b0, 1'b0);
        send_frame(-10'd25, 1'b0, 1'b0);
        send_frame(10'd26,  1'b0, 1'b0);
        send_frame(10'h1ff, 1'b0, 1'b0);
        send_frame(10'h200, 1'b0, 1'b0);
        send_frame(10'd4,   1'b0, 1'b1);
        send_frame(-10'd8,  1'b0, 1'b1);
        send_frame(10'd13,  1'b0, 1'b1);
        send_frame(10'd14,  1'b0, 1'b1);
        send_frame(-10'd26, 1'b0, 1'b1);
        send_frame(10'd100, 1'b1, 1'b0);
        drain();

        // Full-scale center saturates high; vehicle 2 tables
        apply_setting(16'hffff, {14'h3fff, VEH_2});
        send_frame(10'h1ff, 1'b0, 1'b1);
        send_frame(-10'd7,  1'b0, 1'b0);
        send_frame(10'd300, 1'b1, 1'b1);
        drain();

        // Zero center with negative offset saturates low; vehicle 1
        apply_setting(16'h0000, {14'b0, VEH_1});
        send_frame(10'h200, 1'b0, 1'b0);
        send_frame(10'd20,  1'b0, 1'b1);
        drain();

        // Vehicle 0 keeps the gains left by vehicle 1
        apply_setting(16'd30000, 16'h0000);
        send_frame(-10'd100, 1'b0, 1'b0);
        send_frame(10'd0,    1'b1, 1'b0);
        drain();

        // Random phases, each under its own setting
        while (random_sent < RANDOM_FRAMES)
        begin
            roll = $urandom_range(0, 7);
            if (roll == 0)
                center = 16'h0000;
            else if (roll == 1)
                center = 16'hffff;
            else if (roll == 2)
                center = 16'($urandom_range(0, 65535));
            else
                center = 16'($urandom_range(28000, 38000));
            veh_word = 16'($urandom_range(0, 65535));
            apply_setting(center, veh_word);
            steady    = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 60);
            repeat (phase_len)
            begin
                send_frame(pick_offset(), ($urandom_range(0, 99) < 15),
                           1'($urandom_range(0, 1)));
                random_sent++;
            end
            drain();
            steady = 1'b0;
        end

        // drain() already waited out the tail
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
